// ===== hdl/elut_pkg.sv =====
// ----------------------------------------------------------------------------
// elut_pkg
// Shared widths, action codes and constants for the encoder to electrical
// angle lookup unit.
// ----------------------------------------------------------------------------
package elut_pkg;

  // Field widths of the transfers.
  localparam int ANGLE_W = 32;
  localparam int RAW_W   = 21;
  localparam int INDEX_W = 8;

  // A raw encoder angle is placed in the top bits of a 32-bit angle.
  localparam int RAW_SHIFT = ANGLE_W - RAW_W;

  // Restoring divider: one quotient bit per step.
  localparam int DIV_STEPS = ANGLE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [ANGLE_W-1:0] FRAC_ONES = {ANGLE_W{1'b1}};

  // Meaning of the action bit of an input item.
  typedef enum logic {
    ACTION_WRITE  = 1'b0,
    ACTION_LOOKUP = 1'b1
  } action_t;

endpackage

// ===== hdl/elut_if.sv =====
// ----------------------------------------------------------------------------
// elut_if
// Valid/ready channels of the lookup unit: the item channel (table writes and
// lookups) and the result channel.
// ----------------------------------------------------------------------------

// Item channel: a table write or an angle lookup.
interface elut_in_if import elut_pkg::*;;
  logic               valid;
  logic               ready;
  logic               action;
  logic [INDEX_W-1:0] entry_index;
  logic [ANGLE_W-1:0] entry_value;
  logic [RAW_W-1:0]   encoder_angle;

  modport source (
    output valid, action, entry_index, entry_value, encoder_angle,
    input  ready
  );
  modport sink (
    input  valid, action, entry_index, entry_value, encoder_angle,
    output ready
  );
endinterface

// Result channel: one electrical angle per lookup.
interface elut_out_if import elut_pkg::*;;
  logic               valid;
  logic               ready;
  logic [ANGLE_W-1:0] electrical_angle;
  logic [INDEX_W-1:0] segment_index;

  modport source (
    output valid, electrical_angle, segment_index,
    input  ready
  );
  modport sink (
    input  valid, electrical_angle, segment_index,
    output ready
  );
endinterface

// ===== hdl/encoder_to_electrical_angle_lut_unit.sv =====
// ----------------------------------------------------------------------------
// encoder_to_electrical_angle_lut_unit
// Converts a raw encoder angle to an electrical angle by piecewise linear
// interpolation over a loaded calibration table.
// ----------------------------------------------------------------------------
// A write item stores one table point; a write beyond the table is dropped. A
// lookup works on one item at a time: it picks the sector window, runs a
// binary search through the table's single read port, each step a probe and
// a compare (up to five steps with the default sizes), fetches the bracketing
// points (the final probe and two reads), runs the bit-serial divider and
// loads the result register. The unit returns to idle as the result is
// loaded, so the next item can be taken even while that result still waits
// to be taken; a lookup that finishes while an older result is still waiting
// holds until that result is transferred. The table holds nothing after
// reset: every entry that a lookup can reach must be written first.
module encoder_to_electrical_angle_lut_unit import elut_pkg::*; #(
  parameter int TABLE_ENTRIES = 201,
  parameter int SECTORS       = 10
) (
  input  logic        clk,
  input  logic        rst,
  elut_in_if.sink     item,
  elut_out_if.source  result
);

  localparam int IW  = $clog2(TABLE_ENTRIES);
  localparam int WW  = IW + 2;
  localparam int SW  = (SECTORS > 1) ? $clog2(SECTORS) : 1;
  localparam int PW  = RAW_W + SW;
  localparam int PER = (TABLE_ENTRIES - 1) / SECTORS;
  localparam int XW  = IW + INDEX_W;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_WINDOW  = 8'b0000_0010,
    ST_PROBE   = 8'b0000_0100,
    ST_COMPARE = 8'b0000_1000,
    ST_FETCH0  = 8'b0001_0000,
    ST_FETCH1  = 8'b0010_0000,
    ST_DIVIDE  = 8'b0100_0000,
    ST_FINISH  = 8'b1000_0000
  } state_t;

  state_t             state, state_next;
  logic [RAW_W-1:0]   raw;
  logic [ANGLE_W-1:0] angle;
  logic [SW-1:0]      sector;
  logic [IW-1:0]      lo;
  logic [IW-1:0]      hi;
  logic [IW-1:0]      mid;
  logic [IW:0]        mid_sum;
  logic [ANGLE_W-1:0] y0;
  logic               out_valid;
  logic               out_load;
  logic [ANGLE_W-1:0] out_angle;
  logic [INDEX_W-1:0] out_index;

  logic               accept;
  logic               lookup_accept;
  logic               mem_we;
  logic [XW-1:0]      widx;
  logic [IW-1:0]      raddr;
  logic [ANGLE_W-1:0] rdata;
  logic [PW-1:0]      sector_prod;
  logic [SW-1:0]      sector_sel;
  logic [WW-1:0]      win_start;
  logic [WW-1:0]      win_stop;
  logic [WW-1:0]      win_lo;
  logic [WW-1:0]      win_hi;
  logic [XW-1:0]      lo_wide;
  logic               div_start;
  logic               div_done;
  logic [ANGLE_W-1:0] frac;

  // Item handshake; table writes go straight to the memory while idle, so a
  // write never overlaps a lookup's reads.
  assign item.ready    = (state == ST_IDLE);
  assign accept        = item.valid && item.ready;
  assign lookup_accept = accept && (item.action == ACTION_LOOKUP);
  assign widx          = XW'(item.entry_index);
  assign mem_we        = accept && (item.action == ACTION_WRITE)
                         && (widx < XW'(TABLE_ENTRIES));

  assign angle = {raw, {RAW_SHIFT{1'b0}}};

  // Sector from the high word of angle * SECTORS.
  assign sector_prod = PW'(item.encoder_angle) * PW'(SECTORS);
  always_comb begin
    sector_sel = sector_prod[PW-1:RAW_W];
    if (PW'(sector_sel) >= PW'(SECTORS)) begin
      sector_sel = SW'(SECTORS - 1);
    end
  end

  // Search window of the sector, padded and clamped.
  assign win_start = WW'(sector) * WW'(PER);
  assign win_stop  = win_start + WW'(PER + 2);
  assign win_lo    = (win_start > WW'(2)) ? win_start - WW'(2) : '0;
  assign win_hi    = (win_stop < WW'(TABLE_ENTRIES - 2)) ? win_stop
                                                          : WW'(TABLE_ENTRIES - 2);

  // Upper midpoint of the current bounds.
  assign mid_sum = (IW + 1)'(lo) + (IW + 1)'(hi) + 1'b1;
  assign mid     = mid_sum[IW:1];

  // Read address: probe the midpoint, then the found point and its successor.
  always_comb begin
    unique case (state)
      ST_PROBE:  raddr = (lo < hi) ? mid : lo;
      ST_FETCH0: raddr = lo + 1'b1;
      default:   raddr = lo;
    endcase
  end

  elut_mem #(
    .DEPTH (TABLE_ENTRIES),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (widx[IW-1:0]),
    .wdata (item.entry_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Fraction between the two points; rdata holds the next point here.
  assign div_start = (state == ST_FETCH1);

  elut_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (angle - y0),
    .divisor  (rdata - y0),
    .done     (div_done),
    .quotient (frac)
  );

  assign out_load = (state == ST_FINISH) && (!out_valid || result.ready);

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (lookup_accept) state_next = ST_WINDOW;
      ST_WINDOW:  state_next = ST_PROBE;
      ST_PROBE:   state_next = (lo < hi) ? ST_COMPARE : ST_FETCH0;
      ST_COMPARE: state_next = ST_PROBE;
      ST_FETCH0:  state_next = ST_FETCH1;
      ST_FETCH1:  state_next = ST_DIVIDE;
      ST_DIVIDE:  if (div_done) state_next = ST_FINISH;
      ST_FINISH:  if (out_load) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Search bounds and captured operands.
  always_ff @(posedge clk) begin
    if (lookup_accept) begin
      raw    <= item.encoder_angle;
      sector <= sector_sel;
    end
    unique case (state)
      ST_WINDOW: begin
        lo <= win_lo[IW-1:0];
        hi <= win_hi[IW-1:0];
      end
      ST_COMPARE: begin
        if (angle >= rdata) begin
          lo <= mid;
        end else begin
          hi <= mid - 1'b1;
        end
      end
      ST_FETCH0: y0 <= rdata;
      default: ;
    endcase
  end

  // Result register: holds a finished lookup until it is transferred.
  assign lo_wide = XW'(lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_angle <= {lo[1:0], frac[ANGLE_W-1:2]};
      out_index <= lo_wide[INDEX_W-1:0];
    end
  end

  assign result.valid            = out_valid;
  assign result.electrical_angle = out_angle;
  assign result.segment_index    = out_index;

endmodule

// ===== hdl/elut_mem.sv =====
// ----------------------------------------------------------------------------
// elut_mem
// Calibration table storage: one write port and one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module elut_mem import elut_pkg::*; #(
  parameter int DEPTH = 201,
  parameter int AW    = 8
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [ANGLE_W-1:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic [ANGLE_W-1:0] rdata
);

  logic [ANGLE_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/elut_div.sv =====
// ----------------------------------------------------------------------------
// elut_div
// Fraction unit: computes (dividend << 32) / divisor one quotient bit per
// cycle, with the flat-step and past-the-step cases resolved at start.
// ----------------------------------------------------------------------------
module elut_div import elut_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [ANGLE_W-1:0] dividend,
  input  logic [ANGLE_W-1:0] divisor,
  output logic               done,
  output logic [ANGLE_W-1:0] quotient
);

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [ANGLE_W-1:0]   rem;
  logic [ANGLE_W-1:0]   dvs;
  logic [ANGLE_W:0]     trial;

  // Trial subtraction of the shifted remainder; the top bit is the borrow.
  assign trial = {rem, 1'b0} - {1'b0, dvs};

  // Control: busy flag, step counter and the done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= '0;
        if (divisor == '0 || dividend >= divisor) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dvs <= divisor;
      if (divisor == '0) begin
        quotient <= '0;
      end else if (dividend >= divisor) begin
        quotient <= FRAC_ONES;
      end
    end else if (busy) begin
      if (!trial[ANGLE_W]) begin
        rem <= trial[ANGLE_W-1:0];
      end else begin
        rem <= {rem[ANGLE_W-2:0], 1'b0};
      end
      quotient <= {quotient[ANGLE_W-2:0], ~trial[ANGLE_W]};
    end
  end

endmodule

// ===== hdl/elut_chk.sv =====
// ----------------------------------------------------------------------------
// elut_chk
// Port-level checks of the lookup unit, bound to the top level.
// ----------------------------------------------------------------------------
module elut_chk import elut_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_action,
  input logic               out_valid,
  input logic               out_ready,
  input logic [ANGLE_W-1:0] electrical_angle,
  input logic [INDEX_W-1:0] segment_index
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(electrical_angle)
                                && $stable(segment_index))
    else $error("result changed while stalled");

  // A lookup occupies the unit, so the item channel drops ready.
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_action == ACTION_LOOKUP |=> !in_ready)
    else $error("item channel stayed ready after a lookup transfer");

  // The item channel stays ready after a table write.
  a_write_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_action == ACTION_WRITE |=> in_ready)
    else $error("item channel not ready after a table write");

  // The quadrant bits come from the segment index without carry.
  a_quadrant: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> electrical_angle[ANGLE_W-1:ANGLE_W-2] == segment_index[1:0])
    else $error("quadrant does not match segment index");

endmodule

bind encoder_to_electrical_angle_lut_unit elut_chk u_chk (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (item.valid),
  .in_ready         (item.ready),
  .in_action        (item.action),
  .out_valid        (result.valid),
  .out_ready        (result.ready),
  .electrical_angle (result.electrical_angle),
  .segment_index    (result.segment_index)
);
